// ===== hw/rtl/rrrfk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrrfk_pkg
// Shared types, constants and fixed-point helpers for the RRR arm forward
// kinematics block.
// ----------------------------------------------------------------------------
package rrrfk_pkg;

    // Angle constants, Q4.13
    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;

    localparam logic signed [63:0] ROT_MAX = 64'sd16384;
    localparam logic signed [63:0] POS_MAX = 64'sd98304;

    // Horner coefficients after the leading 1/11! = 27 (Q.30)
    localparam logic signed [31:0] SIN_C11 = 32'sd27;
    localparam logic signed [31:0] HCOEF [1:5] = '{
        32'sd2959, 32'sd213045, 32'sd8947849, 32'sd178956971, 32'sd1073741824
    };

    // Configuration register indexes
    localparam logic [1:0] REG_BASE_HEIGHT = 2'd0;
    localparam logic [1:0] REG_UPPER_LINK  = 2'd1;
    localparam logic [1:0] REG_FOREARM     = 2'd2;

    // Folded angles for the six sine evaluations, each within +-pi/2
    typedef struct packed {
        logic signed [14:0] s1;
        logic signed [14:0] c1;
        logic signed [14:0] s2;
        logic signed [14:0] c2;
        logic signed [14:0] s23;
        logic signed [14:0] c23;
    } t_angles;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Round to nearest, halves away from zero, then shift right
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic signed [63:0] half;
        half = 64'sd1 <<< (sh - 1);
        if (v < 0) begin
            return (v + half - 64'sd1) >>> sh;
        end
        return (v + half) >>> sh;
    endfunction

    function automatic logic signed [15:0] sat_rot(input logic signed [63:0] v);
        if (v > ROT_MAX) begin
            return 16'sd16384;
        end
        if (v < -ROT_MAX) begin
            return -16'sd16384;
        end
        return 16'(v);
    endfunction

    function automatic logic signed [17:0] sat_pos(input logic signed [63:0] v);
        if (v > POS_MAX) begin
            return 18'sd98304;
        end
        if (v < -POS_MAX) begin
            return -18'sd98304;
        end
        return 18'(v);
    endfunction

    // One step of wrap into [-pi, pi); enough for every angle range used here
    function automatic logic signed [17:0] ang_wrap(input logic signed [17:0] a);
        if (a >= PI_Q13) begin
            return a - TWO_PI_Q13;
        end
        if (a < -PI_Q13) begin
            return a + TWO_PI_Q13;
        end
        return a;
    endfunction

    // Fold a wrapped angle into [-pi/2, pi/2] keeping its sine
    function automatic logic signed [14:0] ang_fold(input logic signed [17:0] w);
        logic signed [17:0] f;
        if (w > HALF_PI_Q13) begin
            f = PI_Q13 - w;
        end else if (w < -HALF_PI_Q13) begin
            f = -PI_Q13 - w;
        end else begin
            f = w;
        end
        return 15'(f);
    endfunction

endpackage

// ===== hw/rtl/rrr_arm_forward_kinematics_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrr_arm_forward_kinematics_top
// Path from the input transaction to output valid on an empty pipe: front
//   register loaded on the accepting edge, queue write, 8-stage sine units,
//   4 product/rounding stages; the multiply pipe sets the depth.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset: synchronous active-low; clears valids and queue, links return to 1.0.
// Computes the top three rows of the RRR arm end-effector transform.
// ----------------------------------------------------------------------------
module rrr_arm_forward_kinematics_top
    import rrrfk_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // base_angle [15:0], shoulder_angle [31:16], elbow_angle [47:32]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,
    // rot_11 [15:0], rot_12 [31:16], rot_13 [47:32], pos_x [65:48],
    // rot_21 [81:66], rot_22 [97:82], rot_23 [113:98], pos_y [131:114],
    // rot_31 [147:132], rot_32 [163:148], pos_z [181:164], zero pad above
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [183:0] m_axis_tdata,
    // configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [14:0]  i_cfg_data
);

    logic [14:0] r_l1, r_l2, r_l3;
    t_fifo_stat  stat;
    t_angles     front_ang;
    t_angles     head_ang;
    logic        push;
    logic        pop;
    logic [$clog2(FIFO_DEPTH+1)-1:0] level;

    // Link registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= 15'd4096;
            r_l2 <= 15'd4096;
            r_l3 <= 15'd4096;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BASE_HEIGHT: r_l1 <= i_cfg_data;
                REG_UPPER_LINK:  r_l2 <= i_cfg_data;
                REG_FOREARM:     r_l3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rrrfk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_stat     (stat),
        .o_push     (push),
        .o_ang      (front_ang)
    );

    rrrfk_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_ang),
        .i_pop   (pop),
        .o_data  (head_ang),
        .o_stat  (stat),
        .o_level (level)
    );

    rrrfk_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ang      (head_ang),
        .i_stat     (stat),
        .o_pop      (pop),
        .i_l1       (r_l1),
        .i_l2       (r_l2),
        .i_l3       (r_l3),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

    // Checks
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(level) <= FIFO_DEPTH) else $error("queue level above depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.empty |-> !pop) else $error("pop from empty queue");

    a_rot13_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[47:32]) <= 16'sd16384
                           && $signed(m_axis_tdata[47:32]) >= -16'sd16384))
        else $error("rot_13 out of range");

    a_posz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[181:164]) <= 18'sd98304
                           && $signed(m_axis_tdata[181:164]) >= -18'sd98304))
        else $error("pos_z out of range");

endmodule

// ===== hw/rtl/rrrfk_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrrfk_front
// Accepts joint angle transactions, wraps and folds them into the six sine
// arguments, and pushes them into the queue.
// ----------------------------------------------------------------------------
module rrrfk_front
    import rrrfk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // base_angle, shoulder_angle, elbow_angle
    input  t_fifo_stat  i_stat,
    output logic        o_push,
    output t_angles     o_ang
);

    logic              r_valid;
    t_angles           r_ang;
    t_angles           n_ang;
    logic signed [17:0] w1, w2, w23;

    // Wrap and fold
    always_comb begin
        w1  = ang_wrap(18'(signed'(i_s_tdata[15:0])));
        w2  = ang_wrap(18'(signed'(i_s_tdata[31:16])));
        w23 = ang_wrap(18'(signed'(i_s_tdata[31:16])) + 18'(signed'(i_s_tdata[47:32])));
        n_ang.s1  = ang_fold(ang_wrap(w1));
        n_ang.c1  = ang_fold(ang_wrap(w1 + HALF_PI_Q13));
        n_ang.s2  = ang_fold(ang_wrap(w2));
        n_ang.c2  = ang_fold(ang_wrap(w2 + HALF_PI_Q13));
        n_ang.s23 = ang_fold(ang_wrap(w23));
        n_ang.c23 = ang_fold(ang_wrap(w23 + HALF_PI_Q13));
    end

    assign o_push     = r_valid && !i_stat.full;
    assign o_s_tready = !r_valid || !i_stat.full;
    assign o_ang      = r_ang;

    // Holding register ahead of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_ang <= n_ang;
        end
    end

endmodule

// ===== hw/rtl/rrrfk_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrrfk_fifo
// Short queue of prepared angle sets between the front and the back.
// ----------------------------------------------------------------------------
module rrrfk_fifo
    import rrrfk_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_angles                    i_data,
    input  logic                       i_pop,
    output t_angles                    o_data,
    output t_fifo_stat                 o_stat,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_angles         r_mem [DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [LW-1:0]   r_level;

    assign o_stat.full  = (r_level == LW'(DEPTH));
    assign o_stat.empty = (r_level == '0);
    assign o_data       = r_mem[r_rptr];
    assign o_level      = r_level;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/rrrfk_sine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrrfk_sine
// Eight-stage sine of a folded Q1.13 angle, Taylor polynomial through x^11
// by Horner, at most one multiply per stage. Result Q1.14, saturated.
// ----------------------------------------------------------------------------
module rrrfk_sine
    import rrrfk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [14:0] i_ang,
    output logic signed [15:0] o_sin
);

    // x2 in Q.30 is 16*a*a, so products with x2 round by 26 on a*a
    logic signed [14:0] r_a  [1:6];
    logic signed [28:0] r_a2 [1:5];
    logic signed [31:0] r_p  [1:5];
    logic signed [31:0] r_v;
    logic signed [15:0] r_sin;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: square
            r_a[1]  <= i_ang;
            r_a2[1] <= 29'(i_ang * i_ang);
            // stage 2: first Horner step
            r_p[1]  <= 32'(64'(HCOEF[1]) - rnd_shift(64'(SIN_C11) * 64'(r_a2[1]), 26));
            // stages 3..6
            for (int j = 2; j <= 5; j++) begin
                r_p[j] <= 32'(64'(HCOEF[j])
                              - rnd_shift(64'(r_p[j-1]) * 64'(r_a2[j]), 26));
            end
            for (int j = 2; j <= 5; j++) begin
                r_a2[j] <= r_a2[j-1];
            end
            for (int j = 2; j <= 6; j++) begin
                r_a[j] <= r_a[j-1];
            end
            // stage 7: times x
            r_v   <= 32'(rnd_shift(64'(r_p[5]) * 64'(r_a[6]), 13));
            // stage 8: down to Q1.14
            r_sin <= sat_rot(rnd_shift(64'(r_v), 16));
        end
    end

    assign o_sin = r_sin;

endmodule

// ===== hw/rtl/rrrfk_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrrfk_back
// Pops angle sets, runs six sine units, then forms rotation and position
// entries in four more stages. The whole pipe stalls only when its output
// register is full and not taken.
// ----------------------------------------------------------------------------
module rrrfk_back
    import rrrfk_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_angles      i_ang,
    input  t_fifo_stat   i_stat,
    output logic         o_pop,
    input  logic [14:0]  i_l1,
    input  logic [14:0]  i_l2,
    input  logic [14:0]  i_l3,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [183:0] o_m_tdata
);

    localparam int NSTG = 12;

    logic             en;
    logic [NSTG-1:0]  r_vld;
    logic signed [15:0] s1, c1, s2, c2, s23, c23;
    logic signed [16:0] l1, l2, l3;

    // stage B1
    logic signed [31:0] r_m11, r_m12, r_m21, r_m22;
    logic signed [31:0] r_l2c2, r_l3c23, r_l2s2, r_l3s23;
    logic signed [15:0] r_b1_s1, r_b1_c1, r_b1_s23, r_b1_c23;
    // stage B2
    logic signed [15:0] r_r11, r_r12, r_r21, r_r22;
    logic signed [32:0] r_reach;
    logic signed [17:0] r_b2_pz;
    logic signed [15:0] r_b2_s1, r_b2_c1, r_b2_s23, r_b2_c23;
    // stage B3
    logic signed [48:0] r_px_p, r_py_p;
    logic signed [15:0] r_b3_r11, r_b3_r12, r_b3_r21, r_b3_r22;
    logic signed [17:0] r_b3_pz;
    logic signed [15:0] r_b3_s1, r_b3_c1, r_b3_s23, r_b3_c23;
    // output stage
    logic [183:0]       r_out;

    assign en    = !r_vld[NSTG-1] || i_m_tready;
    assign o_pop = en && !i_stat.empty;
    assign l1    = signed'({2'b00, i_l1});
    assign l2    = signed'({2'b00, i_l2});
    assign l3    = signed'({2'b00, i_l3});

    rrrfk_sine u_s1  (.i_clk(i_clk), .i_en(en), .i_ang(i_ang.s1),  .o_sin(s1));
    rrrfk_sine u_c1  (.i_clk(i_clk), .i_en(en), .i_ang(i_ang.c1),  .o_sin(c1));
    rrrfk_sine u_s2  (.i_clk(i_clk), .i_en(en), .i_ang(i_ang.s2),  .o_sin(s2));
    rrrfk_sine u_c2  (.i_clk(i_clk), .i_en(en), .i_ang(i_ang.c2),  .o_sin(c2));
    rrrfk_sine u_s23 (.i_clk(i_clk), .i_en(en), .i_ang(i_ang.s23), .o_sin(s23));
    rrrfk_sine u_c23 (.i_clk(i_clk), .i_en(en), .i_ang(i_ang.c23), .o_sin(c23));

    // Valid tracking through the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], !i_stat.empty};
        end
    end

    // Datapath after the sine units
    always_ff @(posedge i_clk) begin
        if (en) begin
            // B1: products
            r_m11   <= 32'(c1 * c23);
            r_m12   <= 32'(c1 * s23);
            r_m21   <= 32'(s1 * c23);
            r_m22   <= 32'(s1 * s23);
            r_l2c2  <= 32'(l2 * c2);
            r_l3c23 <= 32'(l3 * c23);
            r_l2s2  <= 32'(l2 * s2);
            r_l3s23 <= 32'(l3 * s23);
            r_b1_s1 <= s1;
            r_b1_c1 <= c1;
            r_b1_s23 <= s23;
            r_b1_c23 <= c23;
            // B2: rotation rounding, reach, z
            r_r11   <= sat_rot(rnd_shift(64'(r_m11), 14));
            r_r12   <= -sat_rot(rnd_shift(64'(r_m12), 14));
            r_r21   <= sat_rot(rnd_shift(64'(r_m21), 14));
            r_r22   <= -sat_rot(rnd_shift(64'(r_m22), 14));
            r_reach <= 33'(r_l2c2) + 33'(r_l3c23);
            r_b2_pz <= sat_pos(rnd_shift(64'(l1) * 64'sd16384 + 64'(r_l2s2)
                                         + 64'(r_l3s23), 14));
            r_b2_s1 <= r_b1_s1;
            r_b2_c1 <= r_b1_c1;
            r_b2_s23 <= r_b1_s23;
            r_b2_c23 <= r_b1_c23;
            // B3: x and y products
            r_px_p   <= 49'(r_b2_c1 * r_reach);
            r_py_p   <= 49'(r_b2_s1 * r_reach);
            r_b3_r11 <= r_r11;
            r_b3_r12 <= r_r12;
            r_b3_r21 <= r_r21;
            r_b3_r22 <= r_r22;
            r_b3_pz  <= r_b2_pz;
            r_b3_s1  <= r_b2_s1;
            r_b3_c1  <= r_b2_c1;
            r_b3_s23 <= r_b2_s23;
            r_b3_c23 <= r_b2_c23;
            // B4: output register
            r_out <= {2'b00,
                      r_b3_pz,
                      r_b3_c23,
                      r_b3_s23,
                      sat_pos(rnd_shift(64'(r_py_p), 28)),
                      -r_b3_c1,
                      r_b3_r22,
                      r_b3_r21,
                      sat_pos(rnd_shift(64'(r_px_p), 28)),
                      r_b3_s1,
                      r_b3_r12,
                      r_b3_r11};
        end
    end

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = r_out;

endmodule
